// ===== hw/rtl/i2p_pkg.sv =====
// shared constants, types and character tables of the infix to postfix converter
package i2p_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CODE_W      = 3;
  localparam int SYM_W       = 8;
  localparam int STAT_W      = 2;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

  localparam logic [CODE_W-1:0] OP_PAREN = 3'd0;
  localparam logic [CODE_W-1:0] OP_MUL   = 3'd1;
  localparam logic [CODE_W-1:0] OP_DIV   = 3'd2;
  localparam logic [CODE_W-1:0] OP_ADD   = 3'd3;
  localparam logic [CODE_W-1:0] OP_SUB   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADCHAR  = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;
  localparam logic [STAT_W-1:0] ST_UNBAL    = 2'd3;

  localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [SYM_W-1:0] CH_MUL    = 8'h2a;
  localparam logic [SYM_W-1:0] CH_ADD    = 8'h2b;
  localparam logic [SYM_W-1:0] CH_SUB    = 8'h2d;
  localparam logic [SYM_W-1:0] CH_DIV    = 8'h2f;

  typedef struct packed {
    logic              valid;
    logic [SYM_W-1:0]  sym;
    logic              sym_valid;
    logic              done;
    logic [STAT_W-1:0] status;
  } result_t;

  function automatic logic [SYM_W-1:0] op_char(input logic [CODE_W-1:0] code);
    logic [SYM_W-1:0] c;
    unique case (code)
      OP_MUL:  c = CH_MUL;
      OP_DIV:  c = CH_DIV;
      OP_ADD:  c = CH_ADD;
      OP_SUB:  c = CH_SUB;
      default: c = CH_LPAREN;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] op_level(input logic [CODE_W-1:0] code);
    logic [1:0] l;
    case (code) inside
      OP_MUL, OP_DIV: l = 2'd2;
      OP_ADD, OP_SUB: l = 2'd1;
      default:        l = 2'd0;
    endcase
    return l;
  endfunction

  function automatic logic [CODE_W-1:0] op_code(input logic [SYM_W-1:0] ch);
    logic [CODE_W-1:0] c;
    unique case (ch)
      CH_MUL:  c = OP_MUL;
      CH_DIV:  c = OP_DIV;
      CH_ADD:  c = OP_ADD;
      CH_SUB:  c = OP_SUB;
      default: c = OP_PAREN;
    endcase
    return c;
  endfunction

  function automatic logic is_alnum(input logic [SYM_W-1:0] ch);
    return (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5a) ||
           (ch >= 8'h61 && ch <= 8'h7a);
  endfunction

endpackage

// ===== hw/rtl/i2p_ram.sv =====
// generic single-port-write ram with registered read
module i2p_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/i2p_core.sv =====
// shunting-yard sequencer: operator stack in ram, cached top, one pending result
module i2p_core
  import i2p_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [SYM_W-1:0] in_symbol_in,
  input  logic             in_end_of_expr,
  input  logic             oready,
  output result_t          push
);

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_LOAD, S_END, S_FLUSH, S_DONE, S_ERR
  } state_t;

  state_t            state_r, state_nxt, ret_r, ret_nxt;
  logic [SYM_W-1:0]  ch_r, ch_nxt, pend_sym_r, pend_sym_nxt;
  logic              last_r, last_nxt, pend_v_r, pend_v_nxt;
  logic [CNT_W-1:0]  sc_r, sc_nxt;
  logic [CODE_W-1:0] top_r, top_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CODE_W-1:0] wdata, rdata;
  logic [CODE_W-1:0] code;
  logic              can_emit;
  logic [CNT_W-1:0]  below;
  result_t           pend_res;

  i2p_ram #(.WIDTH(CODE_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // entry under the cached top, read ahead so it is restored in the cycle after a pop
  assign below    = sc_r - CNT_W'(2);
  assign raddr    = below[ADDR_W-1:0];
  assign code     = op_code(ch_r);
  assign can_emit = !pend_v_r || oready;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    pend_res = '{valid: pend_v_r, sym: pend_sym_r, sym_valid: 1'b1, done: 1'b0,
                 status: ST_OK};
  end

  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    ch_nxt       = ch_r;
    last_nxt     = last_r;
    pend_v_nxt   = pend_v_r;
    pend_sym_nxt = pend_sym_r;
    sc_nxt       = sc_r;
    top_nxt      = top_r;
    stat_nxt     = stat_r;
    push         = '0;
    we           = 1'b0;
    waddr        = sc_r[ADDR_W-1:0];
    wdata        = code;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ch_nxt    = in_symbol_in;
          last_nxt  = in_end_of_expr;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (is_alnum(ch_r)) begin
          if (can_emit) begin
            push         = pend_res;
            pend_v_nxt   = 1'b1;
            pend_sym_nxt = ch_r;
            state_nxt    = S_END;
          end
        end else if (ch_r == CH_LPAREN || code != OP_PAREN) begin
          if (code != OP_PAREN && top_r != OP_PAREN &&
              op_level(top_r) >= op_level(code)) begin
            if (can_emit) begin
              push         = pend_res;
              pend_v_nxt   = 1'b1;
              pend_sym_nxt = op_char(top_r);
              sc_nxt       = sc_r - CNT_W'(1);
              ret_nxt      = S_EVAL;
              state_nxt    = S_LOAD;
            end
          end else if (sc_r == DEPTH_CNT) begin
            stat_nxt  = ST_OVERFLOW;
            state_nxt = S_ERR;
          end else begin
            we        = 1'b1;
            top_nxt   = code;
            sc_nxt    = sc_r + CNT_W'(1);
            state_nxt = S_END;
          end
        end else if (ch_r == CH_RPAREN) begin
          if (top_r != OP_PAREN) begin
            if (can_emit) begin
              push         = pend_res;
              pend_v_nxt   = 1'b1;
              pend_sym_nxt = op_char(top_r);
              sc_nxt       = sc_r - CNT_W'(1);
              ret_nxt      = S_EVAL;
              state_nxt    = S_LOAD;
            end
          end else if (sc_r > CNT_W'(1)) begin
            sc_nxt    = sc_r - CNT_W'(1);
            ret_nxt   = S_END;
            state_nxt = S_LOAD;
          end else begin
            stat_nxt  = ST_UNBAL;
            state_nxt = S_ERR;
          end
        end else begin
          stat_nxt  = ST_BADCHAR;
          state_nxt = S_ERR;
        end
      end
      S_LOAD: begin
        top_nxt   = (sc_r == CNT_W'(1)) ? OP_PAREN : rdata;
        state_nxt = ret_r;
      end
      S_END: begin
        if (last_r) begin
          state_nxt = S_FLUSH;
        end else if (can_emit) begin
          push       = pend_res;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (top_r != OP_PAREN) begin
          if (can_emit) begin
            push         = pend_res;
            pend_v_nxt   = 1'b1;
            pend_sym_nxt = op_char(top_r);
            sc_nxt       = sc_r - CNT_W'(1);
            ret_nxt      = S_FLUSH;
            state_nxt    = S_LOAD;
          end
        end else if (sc_r > CNT_W'(1)) begin
          stat_nxt  = ST_UNBAL;
          state_nxt = S_ERR;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (oready) begin
          push = '{valid: 1'b1, sym: pend_v_r ? pend_sym_r : '0, sym_valid: pend_v_r,
                   done: 1'b1, status: ST_OK};
          pend_v_nxt = 1'b0;
          sc_nxt     = CNT_W'(1);
          top_nxt    = OP_PAREN;
          state_nxt  = S_IDLE;
        end
      end
      S_ERR: begin
        if (oready) begin
          if (pend_v_r) begin
            push       = pend_res;
            pend_v_nxt = 1'b0;
          end else begin
            push = '{valid: 1'b1, sym: '0, sym_valid: 1'b0, done: 1'b1,
                     status: stat_r};
            sc_nxt    = CNT_W'(1);
            top_nxt   = OP_PAREN;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    last_r     <= last_nxt;
    pend_sym_r <= pend_sym_nxt;
    stat_r     <= stat_nxt;
    ret_r      <= ret_nxt;
    if (!rst_n) begin
      state_r  <= S_IDLE;
      sc_r     <= CNT_W'(1);
      top_r    <= OP_PAREN;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sc_r     <= sc_nxt;
      top_r    <= top_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    sc_r >= CNT_W'(1) && sc_r <= DEPTH_CNT)
    else $error("stack count out of range");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD && sc_r == CNT_W'(1)) |-> top_r == OP_PAREN)
    else $error("empty stack with operator on top");

  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    (push.valid && push.status != ST_OK) |-> (push.done && !push.sym_valid))
    else $error("error result not marked done");

  a_push_ready: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> oready)
    else $error("result pushed into a full output register");

endmodule

// ===== hw/rtl/infix_to_postfix_converter.sv =====
// infix to postfix converter top level: sequencer plus output register
// Usage: one ASCII character of an infix expression enters per item on the
// in_ channel (in_valid/in_stall), with in_end_of_expr on the final one.
// Letters and digits pass straight to the output; + - * / and parentheses
// are reordered through an operator stack held in a synchronous ram, so the
// out_ channel (out_valid/out_stall) carries the postfix form one character
// per item. The last item of an expression has out_expr_done set; a bad
// character, a stack overflow or unbalanced parentheses ends the expression
// with an item that carries the error in out_status and no character.
// A character goes through S_EVAL and then S_END; each operator it pops
// costs a pop and the ram read that restores the stack top, as does the
// open parenthesis a closing one removes; the final flush pops the rest,
// and an error item follows any pending result. An operand passes through
// the pending result register and the output register before it shows.
// Items are taken one at a time; in_stall is high while one is worked on.
// The output register parts the two channels: while the receiver stalls,
// the held item stays put and the sequencer waits when it has another
// result to hand over. Reset empties the stack to its sentinel and drops
// any output item; the ram itself needs no clearing.
module infix_to_postfix_converter
  import i2p_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [SYM_W-1:0]  in_symbol_in,
  input  logic              in_end_of_expr,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SYM_W-1:0]  out_symbol_out,
  output logic              out_symbol_valid,
  output logic              out_expr_done,
  output logic [STAT_W-1:0] out_status
);

  result_t push;
  logic    oready;
  logic    out_valid_r, out_valid_nxt;
  result_t out_r;

  assign oready = !out_valid_r || !out_stall;

  i2p_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_symbol_in   (in_symbol_in),
    .in_end_of_expr (in_end_of_expr),
    .oready         (oready),
    .push           (push)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (push.valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      out_r <= push;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_symbol_out   = out_r.sym;
  assign out_symbol_valid = out_r.sym_valid;
  assign out_expr_done    = out_r.done;
  assign out_status       = out_r.status;

endmodule
